// ----- hw/rtl/rsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared widths, constants, types and step functions for the radial stick
// dead-zone pipeline.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Field widths
  localparam int AXIS_W = 16;            // raw and output axis, signed Q2.14
  localparam int MAG_W  = 15;            // clamped axis magnitude, 0..16384
  localparam int DZ_W   = 14;            // dead-zone register
  localparam int SQ_W   = 30;            // x*x + y*y, at most 2^29
  localparam int REM_W  = 16;            // square-root partial remainder
  localparam int NUM_W  = 29;            // dividend of every divider
  localparam int Q_W    = 15;            // quotient, at most 16384

  // Step counts of the bit-serial units
  localparam int SQRT_STEPS = SQ_W / 2;  // two radicand bits per stage
  localparam int DIV_STEPS  = Q_W;       // one quotient bit per stage

  // Constants
  localparam logic [MAG_W-1:0] ONE_Q14  = 15'd16384;
  localparam logic [DZ_W-1:0]  DZ_RESET = 14'd2949;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_DEAD_ZONE = 1'b0;   // word index on paddr[2]

  // Sign and magnitude of both clamped axes
  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } axis_side_t;

  // Side data carried across the remap divider
  typedef struct packed {
    axis_side_t       axes;
    logic [Q_W-1:0]   m;
    logic             zero;
  } mid_side_t;

  // Side data carried across the axis dividers
  typedef struct packed {
    logic sx;
    logic sy;
    logic zero;
  } sign_side_t;

  // One square-root stage state
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   root;
  } sqrt_st_t;

  // One divider stage state: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [Q_W-1:0] r;
    logic [Q_W-1:0] nq;
  } div_st_t;

  // Clamp a raw axis to +-1.0 and return its magnitude
  function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [AXIS_W-1:0] raw);
    logic [AXIS_W:0] mag;
    mag = raw[AXIS_W-1] ? (~{raw[AXIS_W-1], raw} + 1'b1) : {raw[AXIS_W-1], raw};
    if (mag > (AXIS_W+1)'(ONE_Q14)) begin
      return ONE_Q14;
    end
    return mag[MAG_W-1:0];
  endfunction

  // Digit-by-digit square root: bring in two radicand bits, settle one root bit
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [1:0] pair);
    logic [REM_W+1:0] r4;
    logic [REM_W+1:0] trial;
    sqrt_st_t         nxt;
    r4    = {cur.rem, pair};
    trial = {1'b0, cur.root, 2'b01};
    if (r4 >= trial) begin
      nxt.rem  = REM_W'(r4 - trial);
      nxt.root = {cur.root[Q_W-2:0], 1'b1};
    end else begin
      nxt.rem  = r4[REM_W-1:0];
      nxt.root = {cur.root[Q_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // Restoring division: shift in one dividend bit, settle one quotient bit
  function automatic div_st_t div_step(input div_st_t cur, input logic [Q_W-1:0] d);
    logic [Q_W:0] t;
    div_st_t      nxt;
    t = {cur.r, cur.nq[Q_W-1]};
    if (t >= {1'b0, d}) begin
      nxt.r  = Q_W'(t - {1'b0, d});
      nxt.nq = {cur.nq[Q_W-2:0], 1'b1};
    end else begin
      nxt.r  = t[Q_W-1:0];
      nxt.nq = {cur.nq[Q_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ----- hw/rtl/rsd_if.sv -----
// ----------------------------------------------------------------------------
// rsd_if
// Valid/ready channels for stick samples and dead-zoned results.
// ----------------------------------------------------------------------------
interface rsd_sample_if;
  import rsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] raw_x;
  logic signed [AXIS_W-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface rsd_result_if;
  import rsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] out_x;
  logic signed [AXIS_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

// ----- hw/rtl/radial_stick_deadzone.sv -----
// ----------------------------------------------------------------------------
// radial_stick_deadzone
// Radial dead zone with rescaling for one two-axis stick in signed Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   sample  : valid/ready channel carrying raw_x, raw_y (signed Q2.14).
//   result  : valid/ready channel carrying out_x, out_y (signed Q2.14).
//   APB     : register 0 at byte address 0 is dead_zone (14 bits, unsigned Q0.14,
//             reset 2949). Write it only while no samples are in flight.
// Timing:
//   Every sample gives one result, and one sample is taken per cycle
//   while the output is not held. The pipeline is made of the bit-serial
//   stages: 15 for the square root, 15 for the remap divider, 15 for the
//   axis dividers, plus clamp, square, remap, multiply and output registers.
// Reset:
//   rst clears every valid bit in the pipeline and loads the default
//   dead zone; no result appears until a new sample is taken.
// Stall:
//   While result.valid is high and result.ready is low the whole pipeline
//   holds and sample.ready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module radial_stick_deadzone (
  input  logic                          clk,
  input  logic                          rst,
  rsd_sample_if.sink                    sample,
  rsd_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsd_pkg::PADDR_W-1:0]   paddr,
  input  logic [rsd_pkg::PDATA_W-1:0]   pwdata,
  output logic [rsd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import rsd_pkg::*;

  // Valid-bit positions along the pipeline
  localparam int V_A   = 0;
  localparam int V_B   = V_A + 1;
  localparam int V_SQ  = V_B + SQRT_STEPS;
  localparam int V_C   = V_SQ + 1;
  localparam int V_D1  = V_C + DIV_STEPS;
  localparam int V_D   = V_D1 + 1;
  localparam int V_D2  = V_D + DIV_STEPS;
  localparam int V_E   = V_D2 + 1;
  localparam int LAT   = V_E + 1;

  logic [DZ_W-1:0]   dead_zone;
  logic              adv;
  logic [LAT-1:0]    vld;

  axis_side_t        a_side;
  axis_side_t        b_side;
  logic [SQ_W-1:0]   b_sq;
  logic [Q_W-1:0]    m;
  axis_side_t        s1 [SQRT_STEPS];

  mid_side_t         c_side;
  logic [NUM_W-1:0]  c_num;
  logic [Q_W-1:0]    c_den;
  logic [Q_W-1:0]    rem;
  mid_side_t         s2 [DIV_STEPS];
  logic              zero_c;
  logic [Q_W-1:0]    cm;

  sign_side_t        d_side;
  logic [NUM_W-1:0]  d_px;
  logic [NUM_W-1:0]  d_py;
  logic [Q_W-1:0]    d_m;
  logic [Q_W-1:0]    qx;
  logic [Q_W-1:0]    qy;
  sign_side_t        s3 [DIV_STEPS];

  logic signed [AXIS_W-1:0] out_x;
  logic signed [AXIS_W-1:0] out_y;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DZ_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEAD_ZONE) begin
      dead_zone <= pwdata[DZ_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEAD_ZONE) begin
      prdata = PDATA_W'(dead_zone);
    end
  end

  // Global advance: the pipeline moves unless the output is held
  assign adv          = !vld[V_E] || result.ready;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  // Stage A: clamp, split into sign and magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      a_side.sx <= sample.raw_x[AXIS_W-1];
      a_side.sy <= sample.raw_y[AXIS_W-1];
      a_side.ax <= clamp_mag(sample.raw_x);
      a_side.ay <= clamp_mag(sample.raw_y);
    end
  end

  // Stage B: sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      b_side <= a_side;
      b_sq   <= SQ_W'(SQ_W'(a_side.ax) * SQ_W'(a_side.ax))
              + SQ_W'(SQ_W'(a_side.ay) * SQ_W'(a_side.ay));
    end
  end

  // Magnitude
  rsd_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .sq   (b_sq),
    .root (m)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1[0] <= b_side;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        s1[i] <= s1[i-1];
      end
    end
  end

  // Stage C: dead-zone test and remap dividend/divisor
  assign zero_c = m <= Q_W'(dead_zone);
  assign cm     = (m > ONE_Q14) ? ONE_Q14 : m;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side.axes <= s1[SQRT_STEPS-1];
      c_side.m    <= m;
      c_side.zero <= zero_c;
      c_num       <= zero_c ? '0 : {Q_W'(cm - Q_W'(dead_zone)), 14'b0};
      c_den       <= ONE_Q14 - Q_W'(dead_zone);
    end
  end

  // Remapped magnitude
  rsd_div u_div_remap (
    .clk (clk),
    .adv (adv),
    .num (c_num),
    .den (c_den),
    .quo (rem)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s2[0] <= c_side;
      for (int i = 1; i < DIV_STEPS; i++) begin
        s2[i] <= s2[i-1];
      end
    end
  end

  // Stage D: scale each axis magnitude by the remapped magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      d_px        <= NUM_W'(s2[DIV_STEPS-1].axes.ax) * NUM_W'(rem);
      d_py        <= NUM_W'(s2[DIV_STEPS-1].axes.ay) * NUM_W'(rem);
      d_m         <= s2[DIV_STEPS-1].m;
      d_side.sx   <= s2[DIV_STEPS-1].axes.sx;
      d_side.sy   <= s2[DIV_STEPS-1].axes.sy;
      d_side.zero <= s2[DIV_STEPS-1].zero;
    end
  end

  // Divide by the raw magnitude; magnitudes truncate toward zero
  rsd_div u_div_x (
    .clk (clk),
    .adv (adv),
    .num (d_px),
    .den (d_m),
    .quo (qx)
  );

  rsd_div u_div_y (
    .clk (clk),
    .adv (adv),
    .num (d_py),
    .den (d_m),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s3[0] <= d_side;
      for (int i = 1; i < DIV_STEPS; i++) begin
        s3[i] <= s3[i-1];
      end
    end
  end

  // Stage E: restore signs, force zero inside the dead zone
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3[DIV_STEPS-1].zero) begin
        out_x <= '0;
        out_y <= '0;
      end else begin
        out_x <= s3[DIV_STEPS-1].sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        out_y <= s3[DIV_STEPS-1].sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      end
    end
  end

  assign result.valid = vld[V_E];
  assign result.out_x = out_x;
  assign result.out_y = out_y;

`ifndef SYNTH
  // Remapped magnitude never exceeds 1.0
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[V_D1] |-> rem <= ONE_Q14)
    else $error("remapped magnitude above 1.0");

  // Results stay within +-1.0
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.out_x <= 16'sd16384 && result.out_x >= -16'sd16384 &&
                      result.out_y <= 16'sd16384 && result.out_y >= -16'sd16384))
    else $error("result outside +-1.0");

  // Each axis product, with its low 14 bits dropped, stays at or below 16384
  a_axis_bound: assert property (@(posedge clk) disable iff (rst)
    vld[V_D] |-> (d_px[NUM_W-1:14] <= (NUM_W-14)'(16384) &&
                  d_py[NUM_W-1:14] <= (NUM_W-14)'(16384)))
    else $error("axis product out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!result.valid && !vld[V_A]))
    else $error("valid data after reset");
`endif

endmodule

// ----- hw/rtl/rsd_isqrt.sv -----
// ----------------------------------------------------------------------------
// rsd_isqrt
// Pipelined floor integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rsd_isqrt (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [rsd_pkg::SQ_W-1:0]   sq,
  output logic [rsd_pkg::Q_W-1:0]    root
);
  import rsd_pkg::*;

  sqrt_st_t         st      [SQRT_STEPS];
  sqrt_st_t         st_next [SQRT_STEPS];
  logic [SQ_W-1:0]  rad     [SQRT_STEPS];
  logic [SQ_W-1:0]  rad_next[SQRT_STEPS];

  // Each stage works on the state left by the one before it
  always_comb begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      if (i == 0) begin
        st_next[i]  = sqrt_step('0, sq[SQ_W-1 -: 2]);
        rad_next[i] = {sq[SQ_W-3:0], 2'b00};
      end else begin
        st_next[i]  = sqrt_step(st[i-1], rad[i-1][SQ_W-1 -: 2]);
        rad_next[i] = {rad[i-1][SQ_W-3:0], 2'b00};
      end
    end
  end

  // Stage registers, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SQRT_STEPS; i++) begin
        st[i]  <= st_next[i];
        rad[i] <= rad_next[i];
      end
    end
  end

  assign root = st[SQRT_STEPS-1].root;

endmodule

// ----- hw/rtl/rsd_div.sv -----
// ----------------------------------------------------------------------------
// rsd_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module rsd_div (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [rsd_pkg::NUM_W-1:0]   num,
  input  logic [rsd_pkg::Q_W-1:0]     den,
  output logic [rsd_pkg::Q_W-1:0]     quo
);
  import rsd_pkg::*;

  div_st_t          st      [DIV_STEPS];
  div_st_t          st_next [DIV_STEPS];
  logic [Q_W-1:0]   d       [DIV_STEPS];
  div_st_t          first;

  // Upper dividend bits are already below the divisor
  always_comb begin
    first.r  = Q_W'(num[NUM_W-1:Q_W]);
    first.nq = num[Q_W-1:0];
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i == 0) begin
        st_next[i] = div_step(first, den);
      end else begin
        st_next[i] = div_step(st[i-1], d[i-1]);
      end
    end
  end

  // Stage registers; the divisor travels with its dividend
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st_next[0];
      d[0]  <= den;
      for (int i = 1; i < DIV_STEPS; i++) begin
        st[i] <= st_next[i];
        d[i]  <= d[i-1];
      end
    end
  end

  assign quo = st[DIV_STEPS-1].nq;

endmodule
